// ----- rtl/mia_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mia_pkg
// Shared widths, types and index helpers for the adjugate matrix inverse.
// ----------------------------------------------------------------------------
package mia_pkg;

    localparam int MAX_DIM   = 3;
    localparam int NLANE     = MAX_DIM * MAX_DIM;
    localparam int ELEM_W    = 16;
    localparam int DIM_W     = 2;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int MINOR_W   = PROD_W + 1;
    localparam int DET_W     = 50;
    localparam int DMAG_W    = DET_W - 1;
    localparam int CMAG_W    = PROD_W - 1;
    localparam int FRAC_SH   = 24;
    localparam int NUM_W     = CMAG_W + FRAC_SH;
    localparam int Q_W       = 33;
    localparam int LANE_LAT  = Q_W + 1;
    localparam int FRONT_LAT = 5;
    localparam int LATENCY   = FRONT_LAT + LANE_LAT + 1;
    localparam int RES_W     = 32;
    localparam int ADDR_W    = 2;
    localparam int DATA_W    = 32;

    localparam logic [RES_W-1:0]  RES_MAX = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0]  RES_MIN = 32'h8000_0000;

    localparam logic [DIM_W-1:0]  SIZE_0 = 2'd0;
    localparam logic [DIM_W-1:0]  SIZE_1 = 2'd1;
    localparam logic [DIM_W-1:0]  SIZE_2 = 2'd2;
    localparam logic [DIM_W-1:0]  SIZE_3 = 2'd3;
    localparam logic [DIM_W-1:0]  SIZE_RESET = SIZE_3;

    localparam logic [ADDR_W-1:0] ADDR_MATRIX_SIZE = 2'd0;

    typedef logic signed [ELEM_W-1:0]  elem_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [MINOR_W-1:0] minor_t;
    typedef logic signed [DET_W-1:0]   det_t;
    typedef logic [RES_W-1:0]          res_t;

    typedef struct packed {
        logic [CMAG_W-1:0] cmag;
        logic              cneg;
        logic              active;
    } lane_in_t;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           ovf;
        logic           cneg;
        logic           active;
    } lane_out_t;

    typedef struct packed {
        logic valid;
        logic dneg;
        logic singular;
    } ctrl_t;

    // lower and upper of the two indices left when index i is struck out
    function automatic int idx_lo(input int i);
        return (i == 0) ? 1 : 0;
    endfunction

    function automatic int idx_hi(input int i);
        return (i == MAX_DIM - 1) ? MAX_DIM - 2 : MAX_DIM - 1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/mia_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mia_front
// Five-stage front end: minors, determinant, adjugate entries per lane.
// ----------------------------------------------------------------------------
module mia_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [mia_pkg::DIM_W-1:0]  dim,
    input  mia_pkg::elem_t             a [mia_pkg::MAX_DIM][mia_pkg::MAX_DIM],
    output mia_pkg::ctrl_t             ctrl,
    output logic [mia_pkg::DMAG_W-1:0] dmag,
    output mia_pkg::lane_in_t          lanes [mia_pkg::NLANE]
);
    import mia_pkg::*;

    logic [FRONT_LAT-1:0] vld_reg;
    logic [DIM_W-1:0]     n1_reg, n2_reg, n3_reg, n4_reg;

    elem_t  m1_reg [MAX_DIM][MAX_DIM];
    elem_t  m2_reg [MAX_DIM][MAX_DIM];
    elem_t  m3_reg [MAX_DIM][MAX_DIM];
    elem_t  m4_reg [MAX_DIM][MAX_DIM];
    prod_t  pa_reg [MAX_DIM][MAX_DIM];
    prod_t  pb_reg [MAX_DIM][MAX_DIM];
    prod_t  pa_next [MAX_DIM][MAX_DIM];
    prod_t  pb_next [MAX_DIM][MAX_DIM];
    minor_t mn3_reg [MAX_DIM][MAX_DIM];
    minor_t mn4_reg [MAX_DIM][MAX_DIM];
    minor_t mn_next [MAX_DIM][MAX_DIM];
    det_t   t_reg   [MAX_DIM];
    det_t   t_next  [MAX_DIM];

    det_t                det;
    logic                dneg_reg, sing_reg;
    logic [DMAG_W-1:0]   dmag_reg;
    lane_in_t            lane_reg  [NLANE];
    lane_in_t            lane_next [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    // two products of every 2x2 minor, the minors and the determinant terms
    always_comb
    begin
        for (int r = 0; r < MAX_DIM; r++)
        begin
            for (int c = 0; c < MAX_DIM; c++)
            begin
                pa_next[r][c] = m1_reg[idx_lo(r)][idx_lo(c)] * m1_reg[idx_hi(r)][idx_hi(c)];
                pb_next[r][c] = m1_reg[idx_lo(r)][idx_hi(c)] * m1_reg[idx_hi(r)][idx_lo(c)];
                mn_next[r][c] = MINOR_W'(pa_reg[r][c]) - MINOR_W'(pb_reg[r][c]);
            end
        end
        for (int c = 0; c < MAX_DIM; c++)
        begin
            t_next[c] = DET_W'(m3_reg[0][c]) * DET_W'(mn3_reg[0][c]);
        end
    end

    // pick determinant and adjugate entries by size
    always_comb
    begin
        minor_t cf;
        logic   flip;
        logic   act;
        unique case (n4_reg)
            SIZE_3:  det = t_reg[0] - t_reg[1] + t_reg[2];
            SIZE_2:  det = DET_W'(mn4_reg[2][2]);
            default: det = DET_W'(m4_reg[0][0]);
        endcase
        for (int r = 0; r < MAX_DIM; r++)
        begin
            for (int c = 0; c < MAX_DIM; c++)
            begin
                flip = 1'((r + c) & 1);
                cf   = '0;
                act  = 1'b0;
                unique case (n4_reg)
                    SIZE_3:
                    begin
                        cf  = mn4_reg[c][r];
                        act = 1'b1;
                    end
                    SIZE_2:
                    begin
                        if (r < 2 && c < 2)
                        begin
                            cf  = MINOR_W'(m4_reg[1 - c][1 - r]);
                            act = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (r == 0 && c == 0)
                        begin
                            cf  = MINOR_W'(1);
                            act = 1'b1;
                        end
                    end
                endcase
                lane_next[r * MAX_DIM + c].cmag   = CMAG_W'(cf[MINOR_W-1] ? -cf : cf);
                lane_next[r * MAX_DIM + c].cneg   = cf[MINOR_W-1] ^ flip;
                lane_next[r * MAX_DIM + c].active = act;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg  <= dim;
        n2_reg  <= n1_reg;
        n3_reg  <= n2_reg;
        n4_reg  <= n3_reg;
        m1_reg  <= a;
        m2_reg  <= m1_reg;
        m3_reg  <= m2_reg;
        m4_reg  <= m3_reg;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        mn3_reg <= mn_next;
        mn4_reg <= mn3_reg;
        t_reg   <= t_next;
        dneg_reg <= det[DET_W-1];
        sing_reg <= (det == '0);
        dmag_reg <= DMAG_W'(det[DET_W-1] ? -det : det);
        lane_reg <= lane_next;
    end

    assign ctrl.valid    = vld_reg[FRONT_LAT-1];
    assign ctrl.dneg     = dneg_reg;
    assign ctrl.singular = sing_reg;
    assign dmag          = dmag_reg;
    assign lanes         = lane_reg;

endmodule
`default_nettype wire

// ----- rtl/mia_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mia_lane
// Pipelined restoring divider: one quotient bit per stage, overflow first.
// ----------------------------------------------------------------------------
module mia_lane (
    input  logic                       clk,
    input  mia_pkg::lane_in_t          lin,
    input  logic [mia_pkg::DMAG_W-1:0] dmag,
    output mia_pkg::lane_out_t         lout
);
    import mia_pkg::*;

    logic [NUM_W-1:0]  rem_reg  [Q_W];
    logic [DMAG_W-1:0] dm_reg   [Q_W];
    logic [Q_W-1:0]    quo_reg  [LANE_LAT];
    logic              ovf_reg  [LANE_LAT];
    logic              cneg_reg [LANE_LAT];
    logic              act_reg  [LANE_LAT];
    logic [NUM_W-1:0]  num;

    assign num = {lin.cmag, {FRAC_SH{1'b0}}};

    // quotient of 2^Q_W or more can only saturate
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num;
        dm_reg[0]   <= dmag;
        quo_reg[0]  <= '0;
        ovf_reg[0]  <= (num >> Q_W) >= NUM_W'(dmag);
        cneg_reg[0] <= lin.cneg;
        act_reg[0]  <= lin.active;
    end

    for (genvar s = 1; s < LANE_LAT; s++)
    begin : g_stage
        localparam int K = Q_W - s;
        logic ge;

        assign ge = (rem_reg[s-1] >> K) >= NUM_W'(dm_reg[s-1]);

        always_ff @(posedge clk)
        begin
            quo_reg[s]  <= {quo_reg[s-1][Q_W-2:0], ge};
            ovf_reg[s]  <= ovf_reg[s-1];
            cneg_reg[s] <= cneg_reg[s-1];
            act_reg[s]  <= act_reg[s-1];
        end

        if (s < Q_W)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? rem_reg[s-1] - (NUM_W'(dm_reg[s-1]) << K)
                                 : rem_reg[s-1];
                dm_reg[s]  <= dm_reg[s-1];
            end
        end
    end

    assign lout.q      = quo_reg[LANE_LAT-1];
    assign lout.ovf    = ovf_reg[LANE_LAT-1];
    assign lout.cneg   = cneg_reg[LANE_LAT-1];
    assign lout.active = act_reg[LANE_LAT-1];

endmodule
`default_nettype wire

// ----- rtl/mia_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mia_merge
// Applies signs, saturates, masks singular matrices and inactive lanes, and registers the result.
// ----------------------------------------------------------------------------
module mia_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mia_pkg::lane_out_t   lo [mia_pkg::NLANE],
    input  mia_pkg::ctrl_t       ctrl,
    output logic                 done,
    output mia_pkg::res_t        res [mia_pkg::NLANE],
    output logic                 singular,
    output logic                 saturated
);
    import mia_pkg::*;

    logic  done_reg;
    res_t  res_reg  [NLANE];
    res_t  res_next [NLANE];
    logic  sing_reg, sat_reg, sat_next;

    always_comb
    begin
        logic neg;
        logic clip;
        sat_next = 1'b0;
        for (int i = 0; i < NLANE; i++)
        begin
            neg  = (lo[i].cneg != ctrl.dneg) && (lo[i].ovf || lo[i].q != '0);
            clip = lo[i].ovf || (neg ? (lo[i].q > Q_W'(RES_MIN)) : (lo[i].q > Q_W'(RES_MAX)));
            if (!lo[i].active || ctrl.singular)
            begin
                res_next[i] = '0;
            end
            else
            begin
                if (clip)
                    res_next[i] = neg ? RES_MIN : RES_MAX;
                else if (neg)
                    res_next[i] = RES_W'(-lo[i].q);
                else
                    res_next[i] = RES_W'(lo[i].q);
                sat_next = sat_next | clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        sing_reg <= ctrl.singular;
        sat_reg  <= sat_next;
    end

    assign done      = done_reg;
    assign res       = res_reg;
    assign singular  = sing_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

// ----- rtl/matrix_inverse_adjugate.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_adjugate
// Fixed-point inverse of the leading n-by-n part of a 3x3 matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with a00..a22 (signed Q8.8) on the ports; busy stays low, so a
//   request is taken in every cycle that start is high.
//   done is high for one cycle with inv00..inv22 (signed Q16.16), singular and
//   saturated after the front end, the lanes and the output register. One
//   matrix per cycle sustained; results leave in request order. The receiver
//   cannot stall. Nine divider lanes of 34 stages, an overflow stage and one
//   quotient bit a stage, follow a five-stage minor and determinant front end.
//   matrix_size (APB, read at byte address 0, written at any address) selects
//   n; 0 acts as 1. Write it only while no request is in flight.
//   Reset drops every request in flight and sets matrix_size to 3.
// ----------------------------------------------------------------------------
module matrix_inverse_adjugate (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [15:0]         a00,
    input  logic signed [15:0]         a01,
    input  logic signed [15:0]         a02,
    input  logic signed [15:0]         a10,
    input  logic signed [15:0]         a11,
    input  logic signed [15:0]         a12,
    input  logic signed [15:0]         a20,
    input  logic signed [15:0]         a21,
    input  logic signed [15:0]         a22,
    output logic                       done,
    output logic signed [31:0]         inv00,
    output logic signed [31:0]         inv01,
    output logic signed [31:0]         inv02,
    output logic signed [31:0]         inv10,
    output logic signed [31:0]         inv11,
    output logic signed [31:0]         inv12,
    output logic signed [31:0]         inv20,
    output logic signed [31:0]         inv21,
    output logic signed [31:0]         inv22,
    output logic                       singular,
    output logic                       saturated,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mia_pkg::ADDR_W-1:0] paddr,
    input  logic [mia_pkg::DATA_W-1:0] pwdata,
    output logic [mia_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import mia_pkg::*;

    logic [DIM_W-1:0]  size_reg;
    logic [DIM_W-1:0]  dim;
    elem_t             a [MAX_DIM][MAX_DIM];
    ctrl_t             f_ctrl;
    logic [DMAG_W-1:0] f_dmag;
    lane_in_t          f_lanes [NLANE];
    lane_out_t         l_out   [NLANE];
    ctrl_t             ctrl_reg [LANE_LAT];
    res_t              res [NLANE];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MATRIX_SIZE) ? DATA_W'(size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_RESET;
        else if (psel && penable && pwrite)
            size_reg <= pwdata[DIM_W-1:0];
    end

    assign dim = (size_reg == SIZE_0) ? SIZE_1 : size_reg;

    assign a[0][0] = a00;
    assign a[0][1] = a01;
    assign a[0][2] = a02;
    assign a[1][0] = a10;
    assign a[1][1] = a11;
    assign a[1][2] = a12;
    assign a[2][0] = a20;
    assign a[2][1] = a21;
    assign a[2][2] = a22;

    mia_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .dim      (dim),
        .a        (a),
        .ctrl     (f_ctrl),
        .dmag     (f_dmag),
        .lanes    (f_lanes)
    );

    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        mia_lane u_lane (
            .clk  (clk),
            .lin  (f_lanes[i]),
            .dmag (f_dmag),
            .lout (l_out[i])
        );
    end

    // carry request control alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LANE_LAT; s++)
                ctrl_reg[s] <= '0;
        end
        else
        begin
            ctrl_reg[0] <= f_ctrl;
            for (int s = 1; s < LANE_LAT; s++)
                ctrl_reg[s] <= ctrl_reg[s-1];
        end
    end

    mia_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lo        (l_out),
        .ctrl      (ctrl_reg[LANE_LAT-1]),
        .done      (done),
        .res       (res),
        .singular  (singular),
        .saturated (saturated)
    );

    assign inv00 = res[0];
    assign inv01 = res[1];
    assign inv02 = res[2];
    assign inv10 = res[3];
    assign inv11 = res[4];
    assign inv12 = res[5];
    assign inv20 = res[6];
    assign inv21 = res[7];
    assign inv22 = res[8];

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not complete after fixed latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching request");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (!saturated && inv00 == 0 && inv11 == 0 && inv22 == 0
                                && inv01 == 0 && inv10 == 0))
        else $error("singular result not cleared");
`endif

endmodule
`default_nettype wire
